>>> rtl/clr_pkg.sv
// Shared types, constants and handshake structs of the clipped line rasterizer.
`default_nettype none

package clr_pkg;

	localparam int SCREEN_WIDTH  = 160;
	localparam int SCREEN_HEIGHT = 120;
	localparam int FRAC_BITS     = 6;
	localparam int SLOPE_BITS    = 16;
	localparam int MAX_GROUPS    = 40;
	localparam int LANES         = 4;

	localparam int IN_W    = 16;
	localparam int ADDR_W  = 15;
	localparam int ONE     = 1 << FRAC_BITS;
	localparam int SHIFT   = FRAC_BITS + SLOPE_BITS;
	localparam int LD_W    = IN_W + 2;
	localparam int PROD_W  = 2 * LD_W;
	localparam int NUM_W   = IN_W - 1 + SHIFT;
	localparam int DEN_W   = IN_W + 1;
	localparam int QUO_W   = NUM_W + 1;
	localparam int CW      = QUO_W + 2;
	localparam int CRD_W   = IN_W;
	localparam int MJ_W    = CRD_W + 1;
	localparam int STEP_W  = SHIFT + 2;
	localparam int ACC_W   = IN_W + SLOPE_BITS + 3;
	localparam int GRP_W   = $clog2(MAX_GROUPS + 1);

	localparam logic signed [CW-1:0] VX_LO = CW'(2 << FRAC_BITS);
	localparam logic signed [CW-1:0] VX_HI = CW'((SCREEN_WIDTH - 2) << FRAC_BITS);
	localparam logic signed [CW-1:0] VY_LO = CW'(2 << FRAC_BITS);
	localparam logic signed [CW-1:0] VY_HI = CW'((SCREEN_HEIGHT - 2) << FRAC_BITS);
	localparam logic signed [CW-1:0] XC_LO = CW'(4 << FRAC_BITS);
	localparam logic signed [CW-1:0] XC_HI = CW'((SCREEN_WIDTH - 4) << FRAC_BITS);
	localparam logic signed [CW-1:0] YC_LO = CW'(4 << FRAC_BITS);
	localparam logic signed [CW-1:0] YC_HI = CW'((SCREEN_HEIGHT - 4) << FRAC_BITS);

	typedef struct packed {
		logic signed [IN_W-1:0] start_x;
		logic signed [IN_W-1:0] start_y;
		logic signed [IN_W-1:0] end_x;
		logic signed [IN_W-1:0] end_y;
	} in_word_t;

	typedef struct packed {
		logic [ADDR_W-1:0] pixel_addr_0;
		logic [ADDR_W-1:0] pixel_addr_1;
		logic [ADDR_W-1:0] pixel_addr_2;
		logic [ADDR_W-1:0] pixel_addr_3;
		logic [LANES-1:0]  lane_valid;
		logic              last_group;
	} out_word_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_CLIP,
		S_DIV_GO,
		S_DIV_WAIT,
		S_VERIFY,
		S_STEP_CHK,
		S_STEP_WAIT,
		S_DRAW,
		S_EMPTY
	} state_t;

	typedef enum logic [1:0] {
		OP_Y0,
		OP_Y1,
		OP_X0,
		OP_X1
	} clip_op_t;

	typedef struct packed {
		logic     load;
		logic     clip_mul;
		logic     clip_div;
		logic     clip_write;
		logic     orient;
		logic     step_div;
		logic     draw_init;
		logic     draw_group;
		logic     emit_empty;
		clip_op_t op;
	} ctrl_cmd_t;

	typedef struct packed {
		logic reject;
		logic clip_need;
		logic div_done;
		logic in_view;
		logic major_zero;
		logic out_free;
		logic group_last;
	} dp_status_t;

endpackage

`default_nettype wire

>>> rtl/clr_div.sv
// Iterative restoring divider, one quotient bit per cycle, sign applied at the end.
`default_nettype none

module clr_div import clr_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [NUM_W-1:0]        num,
	input  wire logic [DEN_W-1:0]        den,
	input  wire logic                    neg,
	output logic                         done,
	output logic signed [QUO_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic              neg_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			neg_q <= neg;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -signed'({1'b0, num_q}) : signed'({1'b0, num_q});

endmodule

`default_nettype wire

>>> rtl/clr_datapath.sv
// Datapath: endpoint registers, clip multiplier, shared divider, DDA lanes, output word.
`default_nettype none

module clr_datapath import clr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire in_word_t   in_data,
	input  wire ctrl_cmd_t  cmd,
	input  wire logic       out_ready,
	output dp_status_t      st,
	output logic            out_valid,
	output out_word_t       out_data
);

	logic signed [CW-1:0]     x_q, y_q, x1_q, y1_q;
	logic signed [IN_W-1:0]   ox_q, oy_q;
	logic signed [LD_W-1:0]   ldx_q, ldy_q;
	logic                     reject_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [DEN_W-1:0]         den_q;
	logic                     dsign_q;
	logic                     xmaj_q;
	logic signed [CRD_W-1:0]  maj_start_q, maj_end_q, min_start_q, min_delta_q;
	logic signed [MJ_W-1:0]   major_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [STEP_W-1:0] step_q;
	logic [GRP_W-1:0]         grp_q;
	logic                     out_valid_q;
	out_word_t                out_q;

	logic signed [CW-1:0]     sx, sy, ex, ey, exn;
	logic                     reject;

	logic                     is_y, below, above;
	logic signed [CW-1:0]     cv, lo, hi, cval, base, obase, new_other;
	logic signed [LD_W-1:0]   diff, mfac, dvs;
	logic signed [PROD_W-1:0] prod;
	logic [PROD_W-1:0]        prod_mag;

	logic signed [CW-1:0]     dx, dy, adx, ady;
	logic                     xmaj, swap;
	logic signed [CW-1:0]     s_x, s_y, s_x1, s_y1;

	logic signed [CRD_W-1:0]  amd;
	logic                     div_start, div_neg, div_done;
	logic [NUM_W-1:0]         div_num;
	logic [DEN_W-1:0]         div_den;
	logic signed [QUO_W-1:0]  quotient;

	logic signed [MJ_W-1:0]   lane_maj [LANES];
	logic signed [ACC_W-1:0]  lane_acc [LANES];
	logic [ADDR_W-1:0]        lane_addr [LANES];
	logic [LANES-1:0]         lane_ok;
	logic [ADDR_W-1:0]        majpix, minpix;
	logic                     group_last;
	out_word_t                grp_word;

	function automatic logic in_range(input logic signed [CW-1:0] v,
		input logic signed [CW-1:0] l, input logic signed [CW-1:0] h);
		return (v >= l) && (v <= h);
	endfunction

	// Input capture and trivial rejection.
	always_comb begin
		sx  = CW'(in_data.start_x);
		sy  = CW'(in_data.start_y);
		ex  = CW'(in_data.end_x);
		ey  = CW'(in_data.end_y);
		exn = (ex == sx) ? ex + CW'(1) : ex;
		reject = (sy < VY_LO && ey < VY_LO) || (sy > VY_HI && ey > VY_HI) ||
			(sx < VX_LO && ex < VX_LO) || (sx > VX_HI && ex > VX_HI);
	end

	// Clip step for the end selected by the controller.
	always_comb begin
		is_y = (cmd.op == OP_Y0) || (cmd.op == OP_Y1);
		unique case (cmd.op)
			OP_Y0:   cv = y_q;
			OP_Y1:   cv = y1_q;
			OP_X0:   cv = x_q;
			default: cv = x1_q;
		endcase
		lo    = is_y ? VY_LO : VX_LO;
		hi    = is_y ? VY_HI : VX_HI;
		below = cv < lo;
		above = cv > hi;
		cval  = is_y ? (below ? YC_LO : YC_HI) : (below ? XC_LO : XC_HI);
		base  = is_y ? CW'(oy_q) : CW'(ox_q);
		obase = is_y ? CW'(ox_q) : CW'(oy_q);
		diff  = LD_W'(cval - base);
		mfac  = is_y ? ldx_q : ldy_q;
		dvs   = is_y ? ldy_q : ldx_q;
		new_other = obase + CW'(quotient);
	end

	assign prod     = diff * mfac;
	assign prod_mag = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);

	// Major axis selection and ordering from the smaller end.
	always_comb begin
		dx   = x1_q - x_q;
		dy   = y1_q - y_q;
		adx  = dx[CW-1] ? -dx : dx;
		ady  = dy[CW-1] ? -dy : dy;
		xmaj = adx > ady;
		swap = xmaj ? (x1_q < x_q) : (y1_q < y_q);
		s_x  = swap ? x1_q : x_q;
		s_y  = swap ? y1_q : y_q;
		s_x1 = swap ? x_q : x1_q;
		s_y1 = swap ? y_q : y1_q;
		amd  = min_delta_q[CRD_W-1] ? -min_delta_q : min_delta_q;
	end

	always_comb begin
		div_start = cmd.clip_div | cmd.step_div;
		if (cmd.step_div) begin
			div_num = NUM_W'(unsigned'(amd)) << SHIFT;
			div_den = DEN_W'(unsigned'(CRD_W'(maj_end_q - maj_start_q)));
			div_neg = min_delta_q[CRD_W-1];
		end else begin
			div_num = NUM_W'(prod_mag);
			div_den = den_q;
			div_neg = prod_q[PROD_W-1] ^ dsign_q;
		end
	end

	clr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (div_num),
		.den      (div_den),
		.neg      (div_neg),
		.done     (div_done),
		.quotient (quotient)
	);

	// Four DDA lanes of the current group.
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			lane_maj[k] = major_q + MJ_W'(k * ONE);
			lane_acc[k] = acc_q + ACC_W'(k) * ACC_W'(step_q);
			lane_ok[k]  = lane_maj[k] < MJ_W'(maj_end_q);
			majpix      = ADDR_W'(lane_maj[k] >>> FRAC_BITS);
			minpix      = lane_acc[k][ACC_W-1] ? '0 : ADDR_W'(lane_acc[k] >>> SHIFT);
			if (!lane_ok[k])
				lane_addr[k] = '0;
			else if (xmaj_q)
				lane_addr[k] = majpix + minpix * ADDR_W'(SCREEN_WIDTH);
			else
				lane_addr[k] = minpix + majpix * ADDR_W'(SCREEN_WIDTH);
		end
		group_last = !(major_q + MJ_W'(LANES * ONE) < MJ_W'(maj_end_q)) ||
			(grp_q == GRP_W'(MAX_GROUPS - 1));
		grp_word.pixel_addr_0 = lane_addr[0];
		grp_word.pixel_addr_1 = lane_addr[1];
		grp_word.pixel_addr_2 = lane_addr[2];
		grp_word.pixel_addr_3 = lane_addr[3];
		grp_word.lane_valid   = lane_ok;
		grp_word.last_group   = group_last;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q      <= sx;
			y_q      <= sy;
			x1_q     <= exn;
			y1_q     <= ey;
			ox_q     <= in_data.start_x;
			oy_q     <= in_data.start_y;
			ldx_q    <= LD_W'(exn - sx);
			ldy_q    <= LD_W'(ey - sy);
			reject_q <= reject;
		end
		if (cmd.clip_mul) begin
			prod_q  <= prod;
			den_q   <= DEN_W'(unsigned'(dvs[LD_W-1] ? -dvs : dvs));
			dsign_q <= dvs[LD_W-1];
			unique case (cmd.op)
				OP_Y0:   y_q  <= cval;
				OP_Y1:   y1_q <= cval;
				OP_X0:   x_q  <= cval;
				default: x1_q <= cval;
			endcase
		end
		if (cmd.clip_write) begin
			unique case (cmd.op)
				OP_Y0:   x_q  <= new_other;
				OP_Y1:   x1_q <= new_other;
				OP_X0:   y_q  <= new_other;
				default: y1_q <= new_other;
			endcase
		end
		if (cmd.orient) begin
			xmaj_q      <= xmaj;
			maj_start_q <= CRD_W'(xmaj ? s_x : s_y);
			maj_end_q   <= CRD_W'(xmaj ? s_x1 : s_y1);
			min_start_q <= CRD_W'(xmaj ? s_y : s_x);
			min_delta_q <= CRD_W'(xmaj ? (s_y1 - s_y) : (s_x1 - s_x));
		end
		if (cmd.draw_init) begin
			step_q  <= STEP_W'(quotient);
			acc_q   <= ACC_W'(min_start_q) <<< SLOPE_BITS;
			major_q <= MJ_W'(maj_start_q);
			grp_q   <= '0;
		end else if (cmd.draw_group) begin
			acc_q   <= acc_q + (ACC_W'(step_q) <<< 2);
			major_q <= major_q + MJ_W'(LANES * ONE);
			grp_q   <= grp_q + GRP_W'(1);
		end
		if (cmd.draw_group)
			out_q <= grp_word;
		else if (cmd.emit_empty)
			out_q <= '{default: '0, last_group: 1'b1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.draw_group || cmd.emit_empty)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_comb begin
		st.reject     = reject_q;
		st.clip_need  = (below || above) && (!is_y || (ldy_q != '0));
		st.div_done   = div_done;
		st.in_view    = in_range(x_q, VX_LO, VX_HI) && in_range(x1_q, VX_LO, VX_HI) &&
			in_range(y_q, VY_LO, VY_HI) && in_range(y1_q, VY_LO, VY_HI);
		st.major_zero = maj_end_q == maj_start_q;
		st.out_free   = !out_valid_q || out_ready;
		st.group_last = group_last;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

>>> rtl/clr_ctrl.sv
// Controller state machine sequencing clipping, slope division and group output.
`default_nettype none

module clr_ctrl import clr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire dp_status_t  st,
	output logic             in_ready,
	output ctrl_cmd_t        cmd
);

	state_t   state_q, state_d;
	clip_op_t op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_Y0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CHECK)
				op_q <= OP_Y0;
			else if (op_q != OP_X1 && ((state_q == S_CLIP && !st.clip_need) ||
				(state_q == S_DIV_WAIT && st.div_done)))
				op_q <= clip_op_t'(op_q + 2'd1);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:      if (in_valid) state_d = S_CHECK;
			S_CHECK:     state_d = st.reject ? S_EMPTY : S_CLIP;
			S_CLIP: begin
				if (st.clip_need)
					state_d = S_DIV_GO;
				else if (op_q == OP_X1)
					state_d = S_VERIFY;
			end
			S_DIV_GO:    state_d = S_DIV_WAIT;
			S_DIV_WAIT: begin
				if (st.div_done)
					state_d = (op_q == OP_X1) ? S_VERIFY : S_CLIP;
			end
			S_VERIFY:    state_d = st.in_view ? S_STEP_CHK : S_EMPTY;
			S_STEP_CHK:  state_d = st.major_zero ? S_EMPTY : S_STEP_WAIT;
			S_STEP_WAIT: if (st.div_done) state_d = S_DRAW;
			S_DRAW:      if (st.out_free && st.group_last) state_d = S_IDLE;
			S_EMPTY:     if (st.out_free) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.op   = op_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_CLIP:      cmd.clip_mul   = st.clip_need;
			S_DIV_GO:    cmd.clip_div   = 1'b1;
			S_DIV_WAIT:  cmd.clip_write = st.div_done;
			S_VERIFY:    cmd.orient     = st.in_view;
			S_STEP_CHK:  cmd.step_div   = !st.major_zero;
			S_STEP_WAIT: cmd.draw_init  = st.div_done;
			S_DRAW:      cmd.draw_group = st.out_free;
			S_EMPTY:     cmd.emit_empty = st.out_free;
			default:     cmd.op         = op_q;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/clipped_line_rasterizer_unit.sv
// Top level of the clipped line rasterizer: controller, datapath and checks.
// A segment that is not rejected is checked, clipped end by end and divided for its slope;
// each clipped end (0 to 4) adds a pass of the shared divider, one quotient bit per iteration.
// A segment rejected at once gives a single word from the empty state after the check.
// Drawing gives one group of four pixels per cycle (1 to 40 groups) while the output side takes words.
// One line is in work at a time; a new segment is taken once its last word is registered.
// Reset clears the controller and the output valid flag; no memory needs clearing.
`default_nettype none

module clipped_line_rasterizer_unit import clr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_word_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_word_t      out_data
);

	ctrl_cmd_t  cmd;
	dp_status_t st;

	clr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.st       (st),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	clr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.out_ready (out_ready),
		.st        (st),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("segment accepted while previous one still in work");

	a_lanes_packed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.lane_valid == 4'b0000 || out_data.lane_valid == 4'b0001 ||
			out_data.lane_valid == 4'b0011 || out_data.lane_valid == 4'b0111 ||
			out_data.lane_valid == 4'b1111))
		else $error("lane valid mask has a gap");

	a_partial_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.lane_valid[3] |-> out_data.last_group)
		else $error("partial group not marked last");

endmodule

`default_nettype wire
